[hdl/delimited_frame_collector_defines.svh]
// ----------------------------------------------------------------------------
// delimited_frame_collector_defines
// Assertion macros shared by the frame collector RTL.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_COLLECTOR_DEFINES_SVH
`define DELIMITED_FRAME_COLLECTOR_DEFINES_SVH

// combinational property, checked every cycle out of reset
`define DFC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// property whose consequence is checked in the cycle after the antecedent
`define DFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dfc_pkg.sv]
// ----------------------------------------------------------------------------
// dfc_pkg
// Types and constants of the delimited frame collector.
// ----------------------------------------------------------------------------
`default_nettype none

package dfc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'b1;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_OUT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_COPY_RD,
        ST_COPY_WR
    } state_t;

endpackage

`default_nettype wire

[hdl/dfc_ram.sv]
// ----------------------------------------------------------------------------
// dfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

[hdl/delimited_frame_collector.sv]
// ----------------------------------------------------------------------------
// delimited_frame_collector
// Collects fixed-length frames between start and end markers from a byte
// stream and emits each complete frame byte by byte.
// ----------------------------------------------------------------------------
// A byte that does not complete a frame is taken at once in the idle state,
// and the next byte can follow right away. A byte that fills the buffer holds
// off input while the block works from its frame RAM (one write port, one
// read port): a good frame is sent byte by byte, each through a RAM read, an
// output load and the handshake, plus any output stall; a bad frame is
// rescanned with a RAM read and a compare per searched position and then
// moved down with a RAM read and a write per kept byte. The buffer needs no
// clearing after reset; the fill count alone tracks which entries hold data.
`default_nettype none

module delimited_frame_collector #(
    parameter int unsigned FRAME_BYTES = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dfc_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [dfc_pkg::BYTE_W-1:0]    m_frame_byte,
    output logic                               m_frame_last,
    input  wire logic                          cfg_we,
    input  wire logic [dfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dfc_pkg::BYTE_W-1:0]    cfg_wdata
);

`include "delimited_frame_collector_defines.svh"

    localparam int unsigned ADDR_W = $clog2(FRAME_BYTES);
    localparam int unsigned CNT_W  = $clog2(FRAME_BYTES + 1);
    localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(FRAME_BYTES);

    dfc_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [ADDR_W-1:0] keep_reg, keep_next;
    logic [dfc_pkg::BYTE_W-1:0] start_marker_reg, end_marker_reg;
    logic m_valid_reg, m_valid_next;
    logic [dfc_pkg::BYTE_W-1:0] frame_byte_reg;
    logic frame_last_reg;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [dfc_pkg::BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [dfc_pkg::BYTE_W-1:0] ram_rdata;

    logic [dfc_pkg::BYTE_W-1:0] cmp_a;
    logic                       cmp_eq;
    logic [CNT_W-1:0]           fill_inc;
    logic                       s_fire;
    logic                       m_fire;

    dfc_ram #(
        .WIDTH (dfc_pkg::BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared start-marker comparator: incoming byte in idle, RAM data in search
    assign cmp_a    = (state_reg == dfc_pkg::ST_IDLE) ? s_rx_byte : ram_rdata;
    assign cmp_eq   = (cmp_a == start_marker_reg);
    assign fill_inc = fill_reg + 1'b1;

    assign s_ready      = (state_reg == dfc_pkg::ST_IDLE);
    assign s_fire       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_fire       = m_valid_reg && m_ready;
    assign m_frame_byte = frame_byte_reg;
    assign m_frame_last = frame_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= dfc_pkg::ST_IDLE;
            fill_reg         <= '0;
            pos_reg          <= '0;
            dst_reg          <= '0;
            keep_reg         <= '0;
            m_valid_reg      <= 1'b0;
            start_marker_reg <= dfc_pkg::START_MARKER_RST;
            end_marker_reg   <= dfc_pkg::END_MARKER_RST;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            dst_reg     <= dst_next;
            keep_reg    <= keep_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    dfc_pkg::REG_START_MARKER: start_marker_reg <= cfg_wdata;
                    dfc_pkg::REG_END_MARKER:   end_marker_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == dfc_pkg::ST_EMIT_LD) begin
            frame_byte_reg <= ram_rdata;
            frame_last_reg <= (pos_reg == LAST_POS);
        end
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        dst_next     = dst_reg;
        keep_next    = keep_reg;
        m_valid_next = m_valid_reg;
        ram_we       = 1'b0;
        ram_waddr    = fill_reg[ADDR_W-1:0];
        ram_wdata    = s_rx_byte;
        ram_raddr    = pos_reg;

        case (state_reg)
            dfc_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (fill_reg == '0) begin
                        if (cmp_eq) begin
                            ram_we    = 1'b1;
                            fill_next = fill_inc;
                        end
                    end else begin
                        ram_we    = 1'b1;
                        fill_next = fill_inc;
                        if (fill_inc == FULL_CNT) begin
                            if (s_rx_byte == end_marker_reg) begin
                                pos_next   = '0;
                                state_next = dfc_pkg::ST_EMIT_RD;
                            end else begin
                                pos_next   = ADDR_W'(1);
                                state_next = dfc_pkg::ST_SRCH_RD;
                            end
                        end
                    end
                end
            end
            dfc_pkg::ST_EMIT_RD: begin
                state_next = dfc_pkg::ST_EMIT_LD;
            end
            dfc_pkg::ST_EMIT_LD: begin
                m_valid_next = 1'b1;
                state_next   = dfc_pkg::ST_EMIT_OUT;
            end
            dfc_pkg::ST_EMIT_OUT: begin
                if (m_fire) begin
                    m_valid_next = 1'b0;
                    if (pos_reg == LAST_POS) begin
                        fill_next  = '0;
                        state_next = dfc_pkg::ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = dfc_pkg::ST_EMIT_RD;
                    end
                end
            end
            dfc_pkg::ST_SRCH_RD: begin
                state_next = dfc_pkg::ST_SRCH_CMP;
            end
            dfc_pkg::ST_SRCH_CMP: begin
                if (cmp_eq) begin
                    keep_next  = ADDR_W'(FULL_CNT - CNT_W'(pos_reg));
                    dst_next   = '0;
                    state_next = dfc_pkg::ST_COPY_RD;
                end else if (pos_reg == LAST_POS) begin
                    fill_next  = '0;
                    state_next = dfc_pkg::ST_IDLE;
                end else begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = dfc_pkg::ST_SRCH_RD;
                end
            end
            dfc_pkg::ST_COPY_RD: begin
                state_next = dfc_pkg::ST_COPY_WR;
            end
            dfc_pkg::ST_COPY_WR: begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg;
                ram_wdata = ram_rdata;
                if (dst_reg == keep_reg - 1'b1) begin
                    fill_next  = CNT_W'(keep_reg);
                    state_next = dfc_pkg::ST_IDLE;
                end else begin
                    pos_next   = pos_reg + 1'b1;
                    dst_next   = dst_reg + 1'b1;
                    state_next = dfc_pkg::ST_COPY_RD;
                end
            end
            default: begin
                state_next = dfc_pkg::ST_IDLE;
            end
        endcase
    end

    `DFC_ASSERT(a_no_input_while_emitting, !(s_ready && m_valid), "input open during emit")
    `DFC_ASSERT(a_idle_not_full, (state_reg != dfc_pkg::ST_IDLE) || (fill_reg < FULL_CNT), "idle with full buffer")
    `DFC_ASSERT_NEXT(a_last_empties, m_fire && m_frame_last, (state_reg == dfc_pkg::ST_IDLE) && (fill_reg == '0), "buffer not emptied after frame")
    `DFC_ASSERT(a_copy_in_range, (state_reg != dfc_pkg::ST_COPY_WR) || (dst_reg < keep_reg), "copy past kept length")

endmodule

`default_nettype wire
